// File: rtl/key_click_classifier_core_macros.svh
// assertion macros for the key click classifier
`ifndef KEY_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define KEY_CLICK_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define KCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kcc same-cycle check failed");

// next-cycle implication, checked out of reset
`define KCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kcc next-cycle check failed");

`endif

// File: rtl/kcc_pkg.sv
`timescale 1ns / 1ps
package kcc_pkg;

  localparam int NUM_KEYS  = 8;
  localparam int LEVEL_W   = 8;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 16;
  localparam int CODE_W    = 2;
  localparam int FLAG_W    = 3;
  localparam int KEY_SEL_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LVL_KEYS  = (NUM_KEYS < LEVEL_W) ? NUM_KEYS : LEVEL_W;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 1'd1;

  localparam logic [CNT_W-1:0] LONG_PRESS_RST    = 16'd50;
  localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RST = 16'd25;
  localparam logic [CNT_W-1:0] CNT_MAX           = '1;

  // operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // pending flag bits
  localparam int FL_PUSH   = 0;
  localparam int FL_LONG   = 1;
  localparam int FL_DOUBLE = 2;

  // event codes
  localparam logic [CODE_W-1:0] EV_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] EV_PUSH   = 2'd1;
  localparam logic [CODE_W-1:0] EV_LONG   = 2'd2;
  localparam logic [CODE_W-1:0] EV_DOUBLE = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_HOLD     = 5'b00100,
    PH_WAIT     = 5'b01000,
    PH_RELEASE  = 5'b10000
  } phase_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/key_click_classifier_core.sv
// key click classifier: every key runs its own classifier (idle, debounce,
// hold counting, double-click wait, wait-for-release). an input item with
// in_tuser = 0 is a scan tick carrying all key levels and updates every key
// at once; it returns nothing. an item with in_tuser = 1 reads one key and
// returns one result item holding its highest-priority pending event (push,
// then long press, then double click), clearing just that flag. the block
// takes one item per clock: the item sits in an input register, all keys
// update in one pass of logic into the state registers, and a read result
// lands in an output register, so in_tready stays high while the result
// waits as long as the input register is empty or holds a tick, or the
// result is being taken. a read result passes the input register and then
// the output register before it is offered. configuration may be written
// only while no item is in flight.
`timescale 1ns / 1ps
`include "key_click_classifier_core_macros.svh"

module key_click_classifier_core
  import kcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] key_levels, [10:8] key_index
  input  logic                  in_tuser,   // [0] op
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] event_code
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [CNT_W-1:0] long_ticks_r;
  logic [CNT_W-1:0] dbl_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_PRESS_RST;
      dbl_window_r <= DOUBLE_WINDOW_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LONG_PRESS:    long_ticks_r <= cfg_wdata;
        REG_DOUBLE_WINDOW: dbl_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  logic               in_vld_r;
  logic               op_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [IDX_W-1:0]   idx_r;
  logic               s1_adv;
  logic               in_fire;

  // output register
  logic              out_vld_r;
  logic [CODE_W-1:0] code_r;

  // an item leaves the input register when it is a tick, or when the
  // output register is free or drains this cycle
  assign s1_adv    = in_vld_r && (op_r == OP_TICK || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (s1_adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_tuser;
      lvl_r <= in_tdata[LEVEL_W-1:0];
      idx_r <= in_tdata[LEVEL_W+IDX_W-1:LEVEL_W];
    end
  end

  logic tick_go;
  logic read_go;
  assign tick_go = s1_adv && (op_r == OP_TICK);
  assign read_go = s1_adv && (op_r == OP_READ);

  // per-key state
  phase_t           phase_r   [NUM_KEYS];
  phase_t           phase_nxt [NUM_KEYS];
  logic [CNT_W-1:0] hold_r    [NUM_KEYS];
  logic [CNT_W-1:0] hold_nxt  [NUM_KEYS];
  logic [CNT_W-1:0] win_r     [NUM_KEYS];
  logic [CNT_W-1:0] win_nxt   [NUM_KEYS];
  logic [FLAG_W-1:0] flags_r  [NUM_KEYS];
  logic [FLAG_W-1:0] flags_nxt[NUM_KEYS];

  // keys beyond the level bits always look released
  logic [NUM_KEYS-1:0] key_prs;
  always_comb begin
    key_prs = '0;
    for (int k = 0; k < LVL_KEYS; k++) begin
      key_prs[k] = lvl_r[k];
    end
  end

  // read side: one key, selected by the item's index
  logic [KEY_SEL_W-1:0] rd_sel;
  logic                 rd_ok;
  logic [FLAG_W-1:0]    rd_flags;
  logic [CODE_W-1:0]    rd_code;

  assign rd_sel   = KEY_SEL_W'(idx_r);
  assign rd_ok    = 32'(idx_r) < 32'(NUM_KEYS);
  assign rd_flags = flags_r[rd_sel];

  always_comb begin
    rd_code = EV_NONE;
    if (rd_ok) begin
      if (rd_flags[FL_PUSH]) begin
        rd_code = EV_PUSH;
      end else if (rd_flags[FL_LONG]) begin
        rd_code = EV_LONG;
      end else if (rd_flags[FL_DOUBLE]) begin
        rd_code = EV_DOUBLE;
      end
    end
  end

  // all keys advance in parallel on a tick; a read clears at most one flag
  always_comb begin
    logic [CNT_W-1:0] h_inc;
    logic [CNT_W-1:0] w_inc;
    for (int k = 0; k < NUM_KEYS; k++) begin
      phase_nxt[k] = phase_r[k];
      hold_nxt[k]  = hold_r[k];
      win_nxt[k]   = win_r[k];
      flags_nxt[k] = flags_r[k];
      h_inc        = sat_inc(hold_r[k]);
      w_inc        = sat_inc(win_r[k]);
      if (tick_go) begin
        case (phase_r[k])
          PH_DEBOUNCE: begin
            if (key_prs[k]) begin
              phase_nxt[k] = PH_HOLD;
              hold_nxt[k]  = '0;
            end else begin
              phase_nxt[k] = PH_IDLE;
            end
          end
          PH_HOLD: begin
            if (key_prs[k]) begin
              if (h_inc >= long_ticks_r) begin
                hold_nxt[k]           = '0;
                phase_nxt[k]          = PH_RELEASE;
                flags_nxt[k][FL_LONG] = 1'b1;
              end else begin
                hold_nxt[k] = h_inc;
              end
            end else begin
              hold_nxt[k]  = '0;
              win_nxt[k]   = '0;
              phase_nxt[k] = PH_WAIT;
            end
          end
          PH_WAIT: begin
            win_nxt[k] = w_inc;
            if (key_prs[k] && w_inc <= dbl_window_r) begin
              phase_nxt[k]            = PH_RELEASE;
              win_nxt[k]              = '0;
              flags_nxt[k][FL_DOUBLE] = 1'b1;
            end else if (!key_prs[k] && w_inc > dbl_window_r) begin
              phase_nxt[k]          = PH_IDLE;
              win_nxt[k]            = '0;
              flags_nxt[k][FL_PUSH] = 1'b1;
            end
          end
          PH_RELEASE: begin
            if (!key_prs[k]) begin
              phase_nxt[k] = PH_IDLE;
            end
          end
          default: begin
            // idle and any stray code
            phase_nxt[k] = key_prs[k] ? PH_DEBOUNCE : PH_IDLE;
          end
        endcase
      end else if (read_go && rd_ok && KEY_SEL_W'(k) == rd_sel) begin
        case (rd_code)
          EV_PUSH:   flags_nxt[k][FL_PUSH]   = 1'b0;
          EV_LONG:   flags_nxt[k][FL_LONG]   = 1'b0;
          EV_DOUBLE: flags_nxt[k][FL_DOUBLE] = 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k] <= PH_IDLE;
        hold_r[k]  <= '0;
        win_r[k]   <= '0;
        flags_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        phase_r[k] <= phase_nxt[k];
        hold_r[k]  <= hold_nxt[k];
        win_r[k]   <= win_nxt[k];
        flags_r[k] <= flags_nxt[k];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (read_go) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (read_go) begin
      code_r <= rd_code;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-CODE_W){1'b0}}, code_r};

  // a read that leaves the input register always shows up as a result
  `KCC_ASSERT_NEXT(a_read_gives_result, read_go, out_tvalid)
  // ticks never create a result
  `KCC_ASSERT_NEXT(a_no_spurious_result, !out_tvalid && !read_go, !out_tvalid)
  // an empty input register never back-pressures
  `KCC_ASSERT_NOW(a_empty_takes_item, !in_vld_r, in_tready)

endmodule
